### rtl/tmlp_pkg.sv
package tmlp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int N_IN = 3;
   localparam int HIDDEN_UNITS = 4;
   localparam int N_OUT = 2;
   localparam int LR_SHIFT = 24;
   localparam int SAT_W = 70;

   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int FWD_STEPS = 4;
   localparam int OUT_STEPS = 3;
   localparam int MRG_STEPS = 3;
   localparam int BWD_STEPS = 19;
   localparam int BWD_W_FIRST = 7;

   typedef logic signed [31:0] word_type;

   typedef enum logic [1:0] {PH_NONE, PH_FWD, PH_OUT, PH_BWD} ph_type;

   typedef struct packed {
      ph_type     ph;
      logic [4:0] step;
   } lane_ctrl_type;

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_FWD, S_OUT, S_MRG, S_POST, S_BWD} st_type;

   // start values, q16.16
   localparam word_type START_HW [N_IN*HIDDEN_UNITS] = '{
      -32'sd101769, 32'sd22484, -32'sd139050, 32'sd84171, -32'sd81497, 32'sd36522,
      32'sd76422, -32'sd240691, -32'sd37438, 32'sd128725, -32'sd130440, -32'sd210825
   };
   localparam word_type START_OW [HIDDEN_UNITS*N_OUT] = '{
      32'sd1717, -32'sd33350, 32'sd170126, -32'sd37945,
      32'sd130589, 32'sd45539, -32'sd113015, 32'sd186778
   };
   localparam word_type START_HB [HIDDEN_UNITS] = '{
      32'sd5913, 32'sd899, 32'sd8091, 32'sd862
   };
   localparam word_type START_OB [N_OUT] = '{32'sd16114, 32'sd10503};

   function automatic word_type sat32(input logic signed [SAT_W-1:0] v);
      word_type r;
      if (v > SAT_W'(64'sh7fffffff)) begin
         r = 32'sh7fffffff;
      end else if (v < -SAT_W'(64'sh80000000)) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/tmlp_div.sv
module tmlp_div import tmlp_pkg::*; (
   input  logic        clock,
   input  logic        start,
   input  logic        run,
   input  logic [15:0] feature,
   input  logic [17:0] sum,
   output logic [16:0] quot
);

   logic [17:0] rem_ff;
   logic        bit_ff;
   logic [16:0] quot_ff;
   logic [18:0] r2;
   logic        ge;
   logic [18:0] diff;

   assign r2   = {rem_ff, bit_ff};
   assign ge   = r2 >= {1'b0, sum};
   assign diff = r2 - {1'b0, sum};
   assign quot = quot_ff;

   // restoring division, one quotient bit a cycle while run is high
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {3'b0, feature[15:1]};
         bit_ff  <= feature[0];
         quot_ff <= '0;
      end else if (run) begin
         rem_ff  <= ge ? diff[17:0] : r2[17:0];
         bit_ff  <= 1'b0;
         quot_ff <= {quot_ff[15:0], ge};
      end
   end

endmodule

### rtl/tmlp_lane.sv
module tmlp_lane import tmlp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          lane_id,
   input  lane_ctrl_type       ctrl,
   input  logic [16:0]         x [N_IN],
   input  logic signed [16:0]  g [N_OUT],
   input  logic [15:0]         lr,
   output logic signed [47:0]  t [N_OUT]
);

   word_type                w_ff [N_IN];
   word_type                b_ff;
   word_type                ow_ff [N_OUT];
   logic [31:0]             h_ff;
   logic signed [35:0]      acc_ff;
   logic signed [68:0]      prod_ff;
   logic signed [33:0]      m_ff;
   logic signed [33:0]      mid_ff;
   logic signed [32:0]      gh_ff [N_OUT];
   logic signed [33:0]      xm_ff;
   logic signed [47:0]      t_ff [N_OUT];

   logic signed [35:0]      ma;
   logic signed [32:0]      mb;
   logic signed [68:0]      prod_in;
   logic signed [68:0]      p16;
   logic signed [68:0]      p24;
   logic [4:0]              rel;
   logic [1:0]              jsel;
   logic [1:0]              sub;
   logic                    hpos;
   word_type                hsat;
   logic signed [32:0]      lr_s;

   assign rel  = ctrl.step - 5'(BWD_W_FIRST);
   assign jsel = rel[3:2];
   assign sub  = rel[1:0];
   assign hpos = h_ff != '0;
   assign lr_s = $signed({17'b0, lr});
   assign p16  = (prod_ff + (69'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   assign p24  = (prod_ff + (69'sd1 <<< (LR_SHIFT - 1))) >>> LR_SHIFT;
   assign hsat = sat32(SAT_W'(acc_ff) + SAT_W'(p16));
   assign t    = t_ff;

   // operand selection for the lane multiplier
   always_comb begin
      ma = '0;
      mb = '0;
      case (ctrl.ph)
         PH_FWD: begin
            if (ctrl.step < 5'd3) begin
               ma = 36'(w_ff[ctrl.step[1:0]]);
               mb = $signed({16'b0, x[ctrl.step[1:0]]});
            end
         end
         PH_OUT: begin
            if (ctrl.step < 5'd2) begin
               ma = 36'(ow_ff[ctrl.step[0]]);
               mb = $signed({1'b0, h_ff});
            end
         end
         PH_BWD: begin
            case (ctrl.step)
               5'd0: begin ma = 36'(ow_ff[0]); mb = 33'(g[0]); end
               5'd1: begin ma = 36'(ow_ff[1]); mb = 33'(g[1]); end
               5'd2: begin ma = $signed({4'b0, h_ff}); mb = 33'(g[0]); end
               5'd3: begin ma = $signed({4'b0, h_ff}); mb = 33'(g[1]); end
               5'd4: begin ma = 36'(mid_ff); mb = lr_s; end
               5'd5: begin ma = 36'(gh_ff[0]); mb = lr_s; end
               5'd6: begin ma = 36'(gh_ff[1]); mb = lr_s; end
               default: begin
                  if (sub == 2'd0) begin
                     ma = 36'(mid_ff);
                     mb = $signed({16'b0, x[jsel]});
                  end else if (sub == 2'd2) begin
                     ma = 36'(xm_ff);
                     mb = lr_s;
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   assign prod_in = ma * mb;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < N_IN; j++) begin
            w_ff[j] <= START_HW[4'(lane_id) * 4'd3 + 4'(j)];
         end
         b_ff     <= START_HB[lane_id];
         ow_ff[0] <= START_OW[3'(lane_id)];
         ow_ff[1] <= START_OW[3'(lane_id) + 3'(HIDDEN_UNITS)];
         h_ff     <= '0;
      end else begin
         prod_ff <= prod_in;
         case (ctrl.ph)
            PH_FWD: begin
               case (ctrl.step)
                  5'd0: acc_ff <= 36'(b_ff);
                  5'd1, 5'd2: acc_ff <= acc_ff + 36'(p16);
                  5'd3: h_ff <= hsat[31] ? '0 : hsat;
                  default: ;
               endcase
            end
            PH_OUT: begin
               case (ctrl.step)
                  5'd1: t_ff[0] <= 48'(p16);
                  5'd2: t_ff[1] <= 48'(p16);
                  default: ;
               endcase
            end
            PH_BWD: begin
               case (ctrl.step)
                  5'd0: ;
                  5'd1: m_ff <= 34'(p16);
                  5'd2: mid_ff <= m_ff + 34'(p16);
                  5'd3: gh_ff[0] <= 33'(p16);
                  5'd4: gh_ff[1] <= 33'(p16);
                  5'd5: begin
                     if (hpos) begin
                        b_ff <= sat32(SAT_W'(b_ff) - SAT_W'(p24));
                     end
                  end
                  5'd6: ow_ff[0] <= sat32(SAT_W'(ow_ff[0]) - SAT_W'(p24));
                  5'd7: ow_ff[1] <= sat32(SAT_W'(ow_ff[1]) - SAT_W'(p24));
                  default: begin
                     if (sub == 2'd1) begin
                        xm_ff <= 34'(p16);
                     end else if (sub == 2'd3 && hpos) begin
                        w_ff[jsel] <= sat32(SAT_W'(w_ff[jsel]) - SAT_W'(p24));
                     end
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

endmodule

### rtl/tiny_mlp_train_step_unit.sv
// a request word runs through the divide, forward, output, merge and post steps, then an update pass
// for training words with a non-zero sum; a new request is taken only once the previous word is done
// the step lengths come from the 17-step serial divide and the per-lane multiplier used for each product
// a new request is taken while the previous result still waits on the output register
// reset: synchronous, restores all weights and biases to their start values and idles
module tiny_mlp_train_step_unit import tmlp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // feature_0, feature_1, feature_2, target_0, target_1, learn_rate
   input  logic         req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata   // class_index, prob_0, prob_1, sum_zero_error
);

   localparam logic [16:0] ONE = 17'(1) << FRAC_BITS;

   st_type              st_ff, st_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                kind_ff;
   logic                zero_ff;
   logic [17:0]         sum_ff;
   logic [16:0]         tgt_ff [N_OUT];
   logic [15:0]         lr_ff;
   word_type            ob_ff [N_OUT];
   word_type            z_ff [N_OUT];
   logic [16:0]         o_ff [N_OUT];
   logic signed [16:0]  g_ff [N_OUT];
   logic                rsp_valid_ff;
   logic [39:0]         rsp_data_ff;

   logic                div_start, div_run, post, ob_upd;
   lane_ctrl_type       lctl;
   logic [15:0]         feat [N_IN];
   logic [17:0]         sum_in;
   logic [16:0]         quot [N_IN];
   logic [16:0]         xs [N_IN];
   logic signed [47:0]  lt [HIDDEN_UNITS][N_OUT];
   logic [16:0]         tgt_in [N_OUT];
   logic                train;

   function automatic logic [16:0] sigmoid_pl(input word_type z);
      logic [32:0] a;
      logic [32:0] y;
      a = z[31] ? 33'(~z) + 33'd1 : 33'(z);
      if (a >= 33'(5) << FRAC_BITS) begin
         y = 33'(ONE);
      end else if (a >= 33'(19) << (FRAC_BITS - 3)) begin
         y = (a >> 5) + (33'(27) << (FRAC_BITS - 5));
      end else if (a >= 33'(ONE)) begin
         y = (a >> 3) + (33'(5) << (FRAC_BITS - 3));
      end else begin
         y = (a >> 2) + (33'(ONE) >> 1);
      end
      return z[31] ? ONE - y[16:0] : y[16:0];
   endfunction

   assign feat[0]   = req_tdata[15:0];
   assign feat[1]   = req_tdata[31:16];
   assign feat[2]   = req_tdata[47:32];
   assign tgt_in[0] = req_tdata[64:48];
   assign tgt_in[1] = req_tdata[81:65];
   assign sum_in    = 18'(feat[0]) + 18'(feat[1]) + 18'(feat[2]);
   assign train     = kind_ff && !zero_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   for (genvar j = 0; j < N_IN; j++) begin : g_div
      tmlp_div u_div (
         .clock   (clock),
         .start   (div_start),
         .run     (div_run),
         .feature (feat[j]),
         .sum     (sum_ff),
         .quot    (quot[j])
      );
      assign xs[j] = zero_ff ? '0 : quot[j];
   end

   for (genvar k = 0; k < HIDDEN_UNITS; k++) begin : g_lane
      tmlp_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .lane_id (2'(k)),
         .ctrl    (lctl),
         .x       (xs),
         .g       (g_ff),
         .lr      (lr_ff),
         .t       (lt[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      st_in      = st_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      div_run    = 1'b0;
      post       = 1'b0;
      ob_upd     = 1'b0;
      lctl       = '{ph: PH_NONE, step: '0};
      case (st_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               div_start = 1'b1;
               st_in     = S_DIV;
               cnt_in    = '0;
            end
         end
         S_DIV: begin
            div_run = 1'b1;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               st_in  = S_FWD;
               cnt_in = '0;
            end
         end
         S_FWD: begin
            lctl   = '{ph: PH_FWD, step: cnt_ff};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(FWD_STEPS - 1)) begin
               st_in  = S_OUT;
               cnt_in = '0;
            end
         end
         S_OUT: begin
            lctl   = '{ph: PH_OUT, step: cnt_ff};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(OUT_STEPS - 1)) begin
               st_in  = S_MRG;
               cnt_in = '0;
            end
         end
         S_MRG: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(MRG_STEPS - 1)) begin
               st_in  = S_POST;
               cnt_in = '0;
            end
         end
         S_POST: begin
            if (!rsp_valid_ff || rsp_tready) begin
               post   = 1'b1;
               st_in  = train ? S_BWD : S_IDLE;
               cnt_in = '0;
            end
         end
         S_BWD: begin
            lctl   = '{ph: PH_BWD, step: cnt_ff};
            ob_upd = cnt_ff == '0;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(BWD_STEPS - 1)) begin
               st_in  = S_IDLE;
               cnt_in = '0;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // request capture, merge of the lane terms, sigmoid, output gradient and bias step
   always_ff @(posedge clock) begin
      logic signed [SAT_W-1:0] zs;
      logic [33:0]             gp;
      logic [15:0]             gm;
      logic signed [33:0]      bp;
      logic signed [33:0]      bs;
      if (reset) begin
         ob_ff[0] <= START_OB[0];
         ob_ff[1] <= START_OB[1];
      end else begin
         if (div_start) begin
            kind_ff <= req_tuser;
            zero_ff <= sum_in == '0;
            sum_ff  <= sum_in;
            lr_ff   <= req_tdata[97:82];
            for (int i = 0; i < N_OUT; i++) begin
               tgt_ff[i] <= (tgt_in[i] > ONE) ? ONE : tgt_in[i];
            end
         end
         if (st_ff == S_MRG) begin
            for (int i = 0; i < N_OUT; i++) begin
               if (cnt_ff == 5'd0) begin
                  zs = SAT_W'(ob_ff[i]);
                  for (int k = 0; k < HIDDEN_UNITS; k++) begin
                     zs = zs + SAT_W'(lt[k][i]);
                  end
                  z_ff[i] <= sat32(zs);
               end else if (cnt_ff == 5'd1) begin
                  o_ff[i] <= sigmoid_pl(z_ff[i]);
               end else begin
                  gp = 34'(ONE - o_ff[i]) * 34'(tgt_ff[i]);
                  gm = 16'((gp + (34'(1) << FRAC_BITS)) >> (FRAC_BITS + 1));
                  g_ff[i] <= 17'sd0 - $signed({1'b0, gm});
               end
            end
         end
         if (ob_upd) begin
            for (int i = 0; i < N_OUT; i++) begin
               bp = 34'(g_ff[i]) * $signed({18'b0, lr_ff});
               bs = (bp + (34'sd1 <<< (LR_SHIFT - 1))) >>> LR_SHIFT;
               ob_ff[i] <= sat32(SAT_W'(ob_ff[i]) - SAT_W'(bs));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (post) begin
         rsp_data_ff <= {4'b0, zero_ff, o_ff[1], o_ff[0], o_ff[0] < o_ff[1]};
      end
   end

   // a waiting result is never overwritten
   a_post_hold: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_POST && rsp_valid_ff && !rsp_tready |=> st_ff == S_POST)
      else $error("result overwritten while waiting");

   // update pass only for training words with a non-zero sum
   a_bwd_gate: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_BWD |-> kind_ff && !zero_ff)
      else $error("update pass on a word that must not train");

   // lanes start only on a finished quotient
   a_fwd_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(st_ff == S_FWD) |-> $past(st_ff) == S_DIV && $past(cnt_ff) == 5'(DIV_STEPS - 1))
      else $error("forward pass before divide finished");

   // a result appears only from the posting step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff) == S_POST)
      else $error("result raised outside posting step");

endmodule

### dv/tiny_mlp_train_step_unit_tb.sv
module tiny_mlp_train_step_unit_tb;
   import tmlp_pkg::*;

   localparam bit KIND_INFER = 1'b0;
   localparam bit KIND_TRAIN = 1'b1;
   localparam int ITEMS = 800;

   class mlp_scoreboard;
      longint hw [N_IN*HIDDEN_UNITS];
      longint ow [HIDDEN_UNITS*N_OUT];
      longint hb [HIDDEN_UNITS];
      longint ob [N_OUT];
      logic [35:0] expected_q [$];
      int errors;

      function new();
         foreach (hw[n]) hw[n] = START_HW[n];
         foreach (ow[n]) ow[n] = START_OW[n];
         foreach (hb[n]) hb[n] = START_HB[n];
         foreach (ob[n]) ob[n] = START_OB[n];
         errors = 0;
      endfunction

      function longint round_shift(longint v, int s);
         if (s == 0) begin
            return v;
         end
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function longint qmul(longint a, longint b);
         return round_shift(a * b, FRAC_BITS);
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function longint squash(longint z);
         longint one, a, y;
         one = longint'(1) << FRAC_BITS;
         a = (z < 0) ? -z : z;
         if (a >= 5 * one) begin
            y = one;
         end else if (a >= (longint'(19) << (FRAC_BITS - 3))) begin
            y = (a >>> 5) + (longint'(27) << (FRAC_BITS - 5));
         end else if (a >= one) begin
            y = (a >>> 3) + (longint'(5) << (FRAC_BITS - 3));
         end else begin
            y = (a >>> 2) + (one >>> 1);
         end
         return (z < 0) ? one - y : y;
      endfunction

      function longint descend(longint w, longint grad, longint lr);
         return clip32(w - round_shift(grad * lr, LR_SHIFT));
      endfunction

      function void note_request(bit kind, logic [15:0] f0, logic [15:0] f1, logic [15:0] f2,
                                 logic [16:0] t0, logic [16:0] t1, logic [15:0] lr);
         longint one, total, acc, t;
         longint f [N_IN];
         longint x [N_IN];
         longint h [HIDDEN_UNITS];
         longint o [N_OUT];
         longint g [N_OUT];
         longint mid [HIDDEN_UNITS];
         longint tg [N_OUT];
         logic [16:0] p [N_OUT];
         bit zero_sum;
         one = longint'(1) << FRAC_BITS;
         f[0] = f0;
         f[1] = f1;
         f[2] = f2;
         tg[0] = t0;
         tg[1] = t1;
         total = f[0] + f[1] + f[2];
         zero_sum = (total == 0);
         for (int j = 0; j < N_IN; j++) x[j] = zero_sum ? 0 : (f[j] * one) / total;
         for (int k = 0; k < HIDDEN_UNITS; k++) begin
            acc = hb[k];
            for (int j = 0; j < N_IN; j++) acc += qmul(hw[N_IN*k+j], x[j]);
            h[k] = clip32(acc);
            if (h[k] < 0) h[k] = 0;
         end
         for (int i = 0; i < N_OUT; i++) begin
            acc = ob[i];
            for (int k = 0; k < HIDDEN_UNITS; k++) acc += qmul(ow[HIDDEN_UNITS*i+k], h[k]);
            o[i] = squash(clip32(acc));
            p[i] = 17'(round_shift(o[i], FRAC_BITS - 16));
         end
         expected_q.push_back({zero_sum, p[1], p[0], (o[0] >= o[1]) ? 1'b0 : 1'b1});
         if (kind == KIND_TRAIN && !zero_sum) begin
            for (int i = 0; i < N_OUT; i++) begin
               t = (tg[i] > 65536) ? 65536 : tg[i];
               t = t << (FRAC_BITS - 16);
               g[i] = -round_shift((one - o[i]) * t, FRAC_BITS + 1);
            end
            for (int k = 0; k < HIDDEN_UNITS; k++) begin
               mid[k] = 0;
               for (int i = 0; i < N_OUT; i++) mid[k] += qmul(ow[HIDDEN_UNITS*i+k], g[i]);
            end
            for (int k = 0; k < HIDDEN_UNITS; k++) begin
               if (h[k] > 0) begin
                  for (int j = 0; j < N_IN; j++)
                     hw[N_IN*k+j] = descend(hw[N_IN*k+j], qmul(x[j], mid[k]), lr);
                  hb[k] = descend(hb[k], mid[k], lr);
               end
            end
            for (int i = 0; i < N_OUT; i++) begin
               for (int k = 0; k < HIDDEN_UNITS; k++)
                  ow[HIDDEN_UNITS*i+k] = descend(ow[HIDDEN_UNITS*i+k], qmul(h[k], g[i]), lr);
               ob[i] = descend(ob[i], g[i], lr);
            end
         end
      endfunction

      function void check_response(logic [39:0] d);
         logic [35:0] e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, d);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (d[0] !== e[0]) begin
            $display("%0t: class_index expected %0d actual %0d", $time, e[0], d[0]);
            errors++;
         end
         if (d[17:1] !== e[17:1]) begin
            $display("%0t: prob_0 expected %0d actual %0d", $time, e[17:1], d[17:1]);
            errors++;
         end
         if (d[34:18] !== e[34:18]) begin
            $display("%0t: prob_1 expected %0d actual %0d", $time, e[34:18], d[34:18]);
            errors++;
         end
         if (d[35] !== e[35]) begin
            $display("%0t: sum_zero_error expected %0d actual %0d", $time, e[35], d[35]);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;  // feature_0, feature_1, feature_2, target_0, target_1, learn_rate
   logic         req_tuser;  // kind
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;  // class_index, prob_0, prob_1, sum_zero_error

   mlp_scoreboard sb;
   bit steady;
   int stall = 0;

   tiny_mlp_train_step_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 60);
   endfunction

   task automatic send_word(bit kind, logic [15:0] f0, logic [15:0] f1, logic [15:0] f2,
                            logic [16:0] t0, logic [16:0] t1, logic [15:0] lr);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'd0, lr, t1, t0, f2, f1, f0};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, f0, f1, f2, t0, t1, lr);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [15:0] f [3];
      logic [16:0] t [2];
      logic [15:0] lr;
      bit kind;
      int m;
      kind = ($urandom_range(0, 3) != 0) ? KIND_TRAIN : KIND_INFER;
      foreach (f[j]) begin
         m = $urandom_range(0, 9);
         f[j] = (m == 0) ? 16'd0 : (m < 3) ? 16'($urandom_range(0, 15)) : 16'($urandom);
      end
      if ($urandom_range(0, 29) == 0) f = '{16'd0, 16'd0, 16'd0};
      foreach (t[i]) begin
         m = $urandom_range(0, 9);
         t[i] = (m == 0) ? 17'd0 : (m == 1) ? 17'd65536 : (m == 2) ? 17'($urandom)
                : 17'($urandom_range(0, 65536));
      end
      m = $urandom_range(0, 9);
      lr = (m == 0) ? 16'($urandom) : (m == 1) ? 16'd0 : 16'($urandom_range(0, 2048));
      send_word(kind, f[0], f[1], f[2], t[0], t[1], lr);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else if (!steady && $urandom_range(0, 199) == 0) begin
            stall <= $urandom_range(8, 60);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) < 70);
         end
      end
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      sb = new();
      steady = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      rsp_tready <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners
      send_word(KIND_INFER, 16'd0, 16'd0, 16'd0, 17'd0, 17'd0, 16'd0);
      send_word(KIND_TRAIN, 16'd0, 16'd0, 16'd0, 17'd65536, 17'd65536, 16'hffff);
      send_word(KIND_INFER, 16'hffff, 16'hffff, 16'hffff, 17'd0, 17'd0, 16'd0);
      send_word(KIND_TRAIN, 16'hffff, 16'd0, 16'd0, 17'd65536, 17'd0, 16'd1000);
      send_word(KIND_TRAIN, 16'd0, 16'hffff, 16'd0, 17'd0, 17'd65536, 16'd1000);
      send_word(KIND_TRAIN, 16'd0, 16'd0, 16'd1, 17'h1ffff, 17'h1ffff, 16'd4000);
      send_word(KIND_TRAIN, 16'd1, 16'd1, 16'd1, 17'd65537, 17'd32768, 16'd0);
      send_word(KIND_TRAIN, 16'h5555, 16'haaaa, 16'h8001, 17'h0aaaa, 17'h15555, 16'h5555);
      send_word(KIND_TRAIN, 16'haaaa, 16'h5555, 16'h7ffe, 17'h15555, 17'h0aaaa, 16'haaaa);
      send_word(KIND_INFER, 16'd7, 16'd300, 16'd0, 17'd65536, 17'd65536, 16'hffff);
      for (int n = 0; n < 6; n++)
         send_word(KIND_TRAIN, 16'd100, 16'd200, 16'd300, 17'd65536, 17'd0, 16'hffff);
      send_word(KIND_INFER, 16'd100, 16'd200, 16'd300, 17'd0, 17'd0, 16'd0);
      for (int n = 0; n < ITEMS; n++) begin
         if (n % 150 == 100) steady = ~steady;
         if (n == ITEMS / 2) begin
            req_tvalid <= 1'b0;
            while (sb.expected_q.size() != 0) @(posedge clock);
         end
         send_random();
      end
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
